// File: rtl/prfl_pkg.sv
// Package for the page replacement unit: sizes, register indexes, policy codes
// and the structs passed between the top level and the frame store.
// No dependencies.
package prfl_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int PAGE_BITS   = 8;

    localparam int PAGE_OUT_W  = 8;
    localparam int COUNT_W     = 4;
    localparam int PAGE_W      = (PAGE_BITS < PAGE_OUT_W) ? PAGE_BITS : PAGE_OUT_W;
    localparam int MAX_IN_USE  = (MAX_FRAMES < 15) ? MAX_FRAMES : 15;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    typedef struct packed {
        logic               clear;
        t_policy            mode;
        logic [COUNT_W-1:0] count;
    } t_frame_cfg;

    typedef struct packed {
        logic                  hit;
        logic                  ev_valid;
        logic [PAGE_OUT_W-1:0] ev_page;
        logic [COUNT_W-1:0]    used;
    } t_frame_res;

endpackage

// File: rtl/prfl_frames.sv
// Frame store with lookup and replacement for FIFO and LRU policies.
// Depends on prfl_pkg.
module prfl_frames (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  prfl_pkg::t_frame_cfg              i_cfg,
    input  logic                              i_step,
    input  logic [prfl_pkg::PAGE_W-1:0]       i_page,
    input  logic                              i_final,
    output prfl_pkg::t_frame_res              o_res
);

    logic [prfl_pkg::PAGE_W-1:0]  r_page [prfl_pkg::MAX_FRAMES];
    logic [prfl_pkg::PAGE_W-1:0]  n_page [prfl_pkg::MAX_FRAMES];
    logic [prfl_pkg::MAX_FRAMES-1:0] r_valid, n_valid;
    logic [prfl_pkg::COUNT_W-1:0] r_ptr, n_ptr;
    logic [prfl_pkg::COUNT_W-1:0] r_fill, n_fill;

    logic [prfl_pkg::COUNT_W-1:0] use_cnt;
    logic [prfl_pkg::COUNT_W-1:0] fill_c;
    logic [prfl_pkg::COUNT_W-1:0] where;
    logic [prfl_pkg::COUNT_W-1:0] victim;
    logic [prfl_pkg::COUNT_W:0]   ptr_inc;
    logic                         hit;
    logic                         victim_valid;
    logic [prfl_pkg::PAGE_W-1:0]  victim_page;
    logic                         do_shift;
    logic [prfl_pkg::COUNT_W-1:0] sh_pos;
    logic [prfl_pkg::COUNT_W-1:0] sh_len;
    logic                         do_fill;

    always_comb begin
        if (i_cfg.count == '0) begin
            use_cnt = prfl_pkg::COUNT_W'(1);
        end else if (i_cfg.count > prfl_pkg::COUNT_W'(prfl_pkg::MAX_IN_USE)) begin
            use_cnt = prfl_pkg::COUNT_W'(prfl_pkg::MAX_IN_USE);
        end else begin
            use_cnt = i_cfg.count;
        end
        fill_c = (r_fill > use_cnt) ? use_cnt : r_fill;
        victim = (r_ptr >= use_cnt) ? '0 : r_ptr;
        ptr_inc = {1'b0, victim} + 1'b1;
    end

    always_comb begin
        hit          = 1'b0;
        where        = '0;
        victim_valid = 1'b0;
        victim_page  = r_page[0];
        for (int k = 0; k < prfl_pkg::MAX_FRAMES; k++) begin
            if (k < int'(use_cnt) && r_valid[k] && r_page[k] == i_page && !hit) begin
                hit   = 1'b1;
                where = prfl_pkg::COUNT_W'(k);
            end
            if (k == int'(victim)) begin
                victim_valid = r_valid[k];
                victim_page  = r_page[k];
            end
        end
    end

    always_comb begin
        n_page   = r_page;
        n_valid  = r_valid;
        n_ptr    = r_ptr;
        n_fill   = r_fill;
        do_shift = 1'b0;
        do_fill  = 1'b0;
        sh_pos   = '0;
        sh_len   = '0;
        o_res.hit      = hit;
        o_res.ev_valid = 1'b0;
        o_res.ev_page  = '0;

        case (i_cfg.mode)
            prfl_pkg::POLICY_FIFO: begin
                if (!hit) begin
                    if (victim_valid) begin
                        o_res.ev_valid = 1'b1;
                        o_res.ev_page  = prfl_pkg::PAGE_OUT_W'(victim_page);
                    end else if (r_fill < use_cnt) begin
                        n_fill = r_fill + 1'b1;
                    end
                    for (int k = 0; k < prfl_pkg::MAX_FRAMES; k++) begin
                        if (k == int'(victim)) begin
                            n_page[k]  = i_page;
                            n_valid[k] = 1'b1;
                        end
                    end
                    n_ptr = (ptr_inc >= {1'b0, use_cnt}) ? '0 : ptr_inc[prfl_pkg::COUNT_W-1:0];
                end
            end
            prfl_pkg::POLICY_LRU: begin
                n_fill = fill_c;
                if (hit) begin
                    do_shift = 1'b1;
                    sh_pos   = where;
                    sh_len   = fill_c;
                end else if (fill_c < use_cnt) begin
                    do_fill = 1'b1;
                    n_fill  = fill_c + 1'b1;
                end else begin
                    o_res.ev_valid = 1'b1;
                    o_res.ev_page  = prfl_pkg::PAGE_OUT_W'(r_page[0]);
                    do_shift = 1'b1;
                    sh_pos   = '0;
                    sh_len   = use_cnt;
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase

        for (int k = 0; k < prfl_pkg::MAX_FRAMES; k++) begin
            if (do_shift) begin
                if (k >= int'(sh_pos) && k + 1 < int'(sh_len)) begin
                    n_page[k]  = r_page[(k + 1 < prfl_pkg::MAX_FRAMES) ? k + 1 : k];
                    n_valid[k] = r_valid[(k + 1 < prfl_pkg::MAX_FRAMES) ? k + 1 : k];
                end
                if (k == int'(sh_len) - 1) begin
                    n_page[k]  = i_page;
                    n_valid[k] = 1'b1;
                end
            end
            if (do_fill && k == int'(fill_c)) begin
                n_page[k]  = i_page;
                n_valid[k] = 1'b1;
            end
        end

        o_res.used = n_fill;

        if (i_final) begin
            n_valid = '0;
            n_ptr   = '0;
            n_fill  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear) begin
            r_valid <= '0;
            r_ptr   <= '0;
            r_fill  <= '0;
        end else if (i_step) begin
            r_valid <= n_valid;
            r_ptr   <= n_ptr;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_page <= n_page;
        end
    end

endmodule

// File: rtl/page_replacement_fifo_lru_unit.sv
// Top level of the FIFO/LRU page replacement unit: input register, config
// registers, result register. Depends on prfl_pkg and prfl_frames.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready    | i_page_ref, i_final_ref
//  result   | o_out_valid / i_out_ready  | o_hit, o_evicted_valid, o_evicted_page,
//           |                            | o_frames_used, o_final_out
//  config   | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// Input then result register; one transaction per cycle unless the result stalls.
// Lookup, victim choice and recency shift run in one pass over the frame registers.
// Synchronous active-low reset empties all frames; policy resets to FIFO, count to 8.
// A stalled result holds the input register, which then stalls the input side.
module page_replacement_fifo_lru_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [prfl_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [prfl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [prfl_pkg::PAGE_OUT_W-1:0]     i_page_ref,
    input  logic                                i_final_ref,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic                                o_evicted_valid,
    output logic [prfl_pkg::PAGE_OUT_W-1:0]     o_evicted_page,
    output logic [prfl_pkg::COUNT_W-1:0]        o_frames_used,
    output logic                                o_final_out
);

    prfl_pkg::t_policy            r_mode;
    logic [prfl_pkg::COUNT_W-1:0] r_count;

    logic                         r_in_valid;
    logic [prfl_pkg::PAGE_W-1:0]  r_in_page;
    logic                         r_in_final;

    logic                         r_out_valid;
    prfl_pkg::t_frame_res         r_res;
    logic                         r_out_final;

    logic                         advance;
    logic                         cfg_hit;
    prfl_pkg::t_frame_cfg         frame_cfg;
    prfl_pkg::t_frame_res         frame_res;

    assign cfg_hit = i_cfg_wr_en && (i_cfg_index == prfl_pkg::REG_POLICY_MODE ||
                                     i_cfg_index == prfl_pkg::REG_FRAME_COUNT);
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign frame_cfg.clear = cfg_hit;
    assign frame_cfg.mode  = r_mode;
    assign frame_cfg.count = r_count;

    prfl_frames u_frames (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (frame_cfg),
        .i_step  (advance),
        .i_page  (r_in_page),
        .i_final (r_in_final),
        .o_res   (frame_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= prfl_pkg::POLICY_FIFO;
            r_count <= prfl_pkg::FRAME_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                prfl_pkg::REG_POLICY_MODE: r_mode  <= prfl_pkg::t_policy'(i_cfg_data[0]);
                prfl_pkg::REG_FRAME_COUNT: r_count <= i_cfg_data[prfl_pkg::COUNT_W-1:0];
                default:                   r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_page  <= i_page_ref[prfl_pkg::PAGE_W-1:0];
            r_in_final <= i_final_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res       <= frame_res;
            r_out_final <= r_in_final;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_res.hit;
    assign o_evicted_valid = r_res.ev_valid;
    assign o_evicted_page  = r_res.ev_page;
    assign o_frames_used   = r_res.used;
    assign o_final_out     = r_out_final;

`ifndef NO_ASSERTIONS
    a_evict_only_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted_valid |-> !o_hit)
        else $error("eviction reported on a hit");

    a_no_page_without_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frames_used <= prfl_pkg::COUNT_W'(prfl_pkg::MAX_IN_USE))
        else $error("frames used above capacity");

    a_fault_fills_or_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit && !o_evicted_valid && !o_final_out |-> o_frames_used != '0)
        else $error("fault loaded no frame");
`endif

endmodule
